[design/movd_pkg.sv]
// movd_pkg: shared types and codes for the mov instruction stream decoder
// opcode classes, status and form codes, the decoded result record
// no dependencies
package movd_pkg;

	localparam logic [2:0] CLS_RM   = 3'd0;
	localparam logic [2:0] CLS_IRM  = 3'd1;
	localparam logic [2:0] CLS_IREG = 3'd2;
	localparam logic [2:0] CLS_MACC = 3'd3;
	localparam logic [2:0] CLS_AMEM = 3'd4;
	localparam logic [2:0] CLS_SEG  = 3'd5;
	localparam logic [2:0] CLS_BAD  = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BAD   = 2'd1;
	localparam logic [1:0] ST_SEG   = 2'd2;
	localparam logic [1:0] ST_TRUNC = 2'd3;

	localparam logic [2:0] FORM_RM   = 3'd0;
	localparam logic [2:0] FORM_IRM  = 3'd1;
	localparam logic [2:0] FORM_IREG = 3'd2;
	localparam logic [2:0] FORM_MACC = 3'd3;
	localparam logic [2:0] FORM_AMEM = 3'd4;

	localparam logic [7:0] MASK_RM   = 8'b11111100;
	localparam logic [7:0] OPC_RM    = 8'b10001000;
	localparam logic [7:0] MASK_W    = 8'b11111110;
	localparam logic [7:0] OPC_IRM   = 8'b11000110;
	localparam logic [7:0] MASK_IREG = 8'b11110000;
	localparam logic [7:0] OPC_IREG  = 8'b10110000;
	localparam logic [7:0] OPC_MACC  = 8'b10100000;
	localparam logic [7:0] OPC_AMEM  = 8'b10100010;
	localparam logic [7:0] OPC_SEG_TO   = 8'b10001110;
	localparam logic [7:0] OPC_SEG_FROM = 8'b10001100;

	localparam logic [2:0] RM_DIRECT = 3'd6;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  form;
		logic        word_size;
		logic        to_register;
		logic [2:0]  reg_code;
		logic [1:0]  mode_bits;
		logic [2:0]  rm_code;
		logic        direct_address;
		logic [15:0] displacement;
		logic [15:0] immediate;
		logic [2:0]  length;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t data;
	} gather_out_t;

endpackage

[design/movd_if.sv]
// movd_if: valid/ready channels of the mov instruction stream decoder
// movd_byte_if carries code bytes, movd_result_if carries decoded instructions
// depends on movd_pkg
interface movd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       stream_end;

	modport source (output valid, output code_byte, output stream_end, input ready);
	modport sink (input valid, input code_byte, input stream_end, output ready);
endinterface

interface movd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [2:0]  form;
	logic        word_size;
	logic        to_register;
	logic [2:0]  reg_code;
	logic [1:0]  mode_bits;
	logic [2:0]  rm_code;
	logic        direct_address;
	logic [15:0] displacement;
	logic [15:0] immediate;
	logic [2:0]  length;

	modport source (output valid, output status, output form, output word_size,
		output to_register, output reg_code, output mode_bits, output rm_code,
		output direct_address, output displacement, output immediate, output length,
		input ready);
	modport sink (input valid, input status, input form, input word_size,
		input to_register, input reg_code, input mode_bits, input rm_code,
		input direct_address, input displacement, input immediate, input length,
		output ready);
endinterface

[design/mov_instruction_stream_decoder.sv]
// mov_instruction_stream_decoder: top level, byte channel in, decoded mov out
// a result is registered and valid in the cycle after its last byte is taken
// throughput: one code byte per cycle while the result register can take it
// reset: position and holding registers clear, no result pending
// depends on movd_pkg, movd_if, movd_gather
module mov_instruction_stream_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	movd_byte_if.sink            byte_ch,
	movd_result_if.source        result_ch
);

	logic                  step;
	logic                  res_valid_q;
	movd_pkg::result_t     res_q;
	movd_pkg::gather_out_t gout;

	assign byte_ch.ready = !res_valid_q || result_ch.ready;
	assign step = byte_ch.valid && byte_ch.ready;

	movd_gather u_gather (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.code_byte  (byte_ch.code_byte),
		.stream_end (byte_ch.stream_end),
		.gout       (gout)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= gout.valid;
		end else if (result_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && gout.valid) begin
			res_q <= gout.data;
		end
	end

	assign result_ch.valid          = res_valid_q;
	assign result_ch.status         = res_q.status;
	assign result_ch.form           = res_q.form;
	assign result_ch.word_size      = res_q.word_size;
	assign result_ch.to_register    = res_q.to_register;
	assign result_ch.reg_code       = res_q.reg_code;
	assign result_ch.mode_bits      = res_q.mode_bits;
	assign result_ch.rm_code        = res_q.rm_code;
	assign result_ch.direct_address = res_q.direct_address;
	assign result_ch.displacement   = res_q.displacement;
	assign result_ch.immediate      = res_q.immediate;
	assign result_ch.length         = res_q.length;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_ch.valid |-> byte_ch.ready)
		else $error("byte channel stalled with no result pending");

	a_bad_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.status == movd_pkg::ST_BAD
		|-> (result_ch.length == 3'd1 || result_ch.length == 3'd2)
		&& result_ch.displacement == 16'h0000 && result_ch.form == movd_pkg::FORM_RM)
		else $error("invalid opcode transaction carries decoded fields");

	a_ok_length: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.status == movd_pkg::ST_OK
		|-> result_ch.length >= 3'd2)
		else $error("complete instruction shorter than two bytes");

	a_acc_direct: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && (result_ch.form == movd_pkg::FORM_MACC
		|| result_ch.form == movd_pkg::FORM_AMEM)
		|-> result_ch.direct_address && result_ch.rm_code == movd_pkg::RM_DIRECT)
		else $error("accumulator form without direct address");

endmodule

[design/movd_gather.sv]
// movd_gather: per-instruction byte gathering and field decode
// holds the partial instruction, emits a decoded record on its last byte
// depends on movd_pkg
module movd_gather (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           code_byte,
	input  logic                 stream_end,
	output movd_pkg::gather_out_t gout
);

	function automatic logic [2:0] classify(input logic [7:0] op);
		logic [2:0] c;
		if ((op & movd_pkg::MASK_RM) == movd_pkg::OPC_RM) c = movd_pkg::CLS_RM;
		else if ((op & movd_pkg::MASK_W) == movd_pkg::OPC_IRM) c = movd_pkg::CLS_IRM;
		else if ((op & movd_pkg::MASK_IREG) == movd_pkg::OPC_IREG) c = movd_pkg::CLS_IREG;
		else if ((op & movd_pkg::MASK_W) == movd_pkg::OPC_MACC) c = movd_pkg::CLS_MACC;
		else if ((op & movd_pkg::MASK_W) == movd_pkg::OPC_AMEM) c = movd_pkg::CLS_AMEM;
		else if (op == movd_pkg::OPC_SEG_TO || op == movd_pkg::OPC_SEG_FROM)
			c = movd_pkg::CLS_SEG;
		else c = movd_pkg::CLS_BAD;
		return c;
	endfunction

	function automatic logic [2:0] disp_len(input logic [7:0] modrm);
		logic [2:0] n;
		priority if (modrm[7:6] == 2'd1) n = 3'd1;
		else if (modrm[7:6] == 2'd2) n = 3'd2;
		else if (modrm[7:6] == 2'd0 && modrm[2:0] == movd_pkg::RM_DIRECT) n = 3'd2;
		else n = 3'd0;
		return n;
	endfunction

	function automatic logic [15:0] place(input logic [7:0] b, input logic hi);
		return hi ? {b, 8'h00} : {8'h00, b};
	endfunction

	logic [2:0]  pos_q;
	logic [7:0]  opcode_q;
	logic [7:0]  modrm_q;
	logic [15:0] disp_q;
	logic [15:0] imm_q;
	logic [2:0]  explen_q;

	logic [7:0]  opcode_n;
	logic [7:0]  modrm_n;
	logic [15:0] disp_n;
	logic [15:0] imm_n;
	logic [2:0]  explen_n;
	logic [2:0]  pos_n;
	logic [2:0]  cls;
	logic [2:0]  k;
	logic [2:0]  dl;
	logic [2:0]  imm_k;
	logic        done;
	logic        last;
	logic        is_modrm;
	movd_pkg::result_t res;

	always_comb begin
		opcode_n = opcode_q;
		modrm_n  = modrm_q;
		disp_n   = disp_q;
		imm_n    = imm_q;
		explen_n = explen_q;
		k        = pos_q - 3'd2;
		dl       = disp_len(modrm_q);
		imm_k    = k - dl;
		if (pos_q == 3'd0) begin
			opcode_n = code_byte;
			modrm_n  = 8'h00;
			disp_n   = 16'h0000;
			imm_n    = 16'h0000;
		end
		cls = classify(opcode_n);
		is_modrm = (cls == movd_pkg::CLS_RM) || (cls == movd_pkg::CLS_IRM)
			|| (cls == movd_pkg::CLS_SEG);
		if (pos_q == 3'd0) begin
			unique case (cls)
				movd_pkg::CLS_IREG: explen_n = code_byte[3] ? 3'd3 : 3'd2;
				movd_pkg::CLS_MACC, movd_pkg::CLS_AMEM: explen_n = 3'd3;
				default: explen_n = 3'd2;
			endcase
		end else if (is_modrm) begin
			if (pos_q == 3'd1) begin
				modrm_n  = code_byte;
				explen_n = 3'd2 + disp_len(code_byte)
					+ ((cls == movd_pkg::CLS_IRM) ? {2'b00, 1'b1} + {2'b00, opcode_q[0]} : 3'd0);
			end else if (k < dl) begin
				disp_n = disp_q | place(code_byte, k[0]);
			end else begin
				imm_n = imm_q | place(code_byte, imm_k[0]);
			end
		end else if (cls == movd_pkg::CLS_IREG) begin
			imm_n = imm_q | place(code_byte, ~pos_q[0]);
		end else if (cls == movd_pkg::CLS_MACC || cls == movd_pkg::CLS_AMEM) begin
			disp_n = disp_q | place(code_byte, ~pos_q[0]);
		end
		pos_n = pos_q + 3'd1;
		done  = pos_n >= explen_n;
		last  = done || stream_end;
	end

	// decoded record from the updated holding registers
	always_comb begin
		res = '0;
		res.length = pos_n;
		priority if (cls == movd_pkg::CLS_BAD) res.status = movd_pkg::ST_BAD;
		else if (!done) res.status = movd_pkg::ST_TRUNC;
		else if (cls == movd_pkg::CLS_SEG) res.status = movd_pkg::ST_SEG;
		else res.status = movd_pkg::ST_OK;
		if (cls != movd_pkg::CLS_BAD) begin
			res.displacement = disp_n;
			res.immediate    = imm_n;
			if (is_modrm) begin
				res.form        = (cls == movd_pkg::CLS_IRM) ? movd_pkg::FORM_IRM
					: movd_pkg::FORM_RM;
				res.word_size   = (cls == movd_pkg::CLS_SEG) ? 1'b1 : opcode_n[0];
				res.to_register = (cls == movd_pkg::CLS_IRM) ? 1'b0 : opcode_n[1];
				res.reg_code    = modrm_n[5:3];
				res.mode_bits   = modrm_n[7:6];
				res.rm_code     = modrm_n[2:0];
				res.direct_address = (modrm_n[7:6] == 2'd0)
					&& (modrm_n[2:0] == movd_pkg::RM_DIRECT);
			end else if (cls == movd_pkg::CLS_IREG) begin
				res.form        = movd_pkg::FORM_IREG;
				res.word_size   = opcode_n[3];
				res.to_register = 1'b1;
				res.reg_code    = opcode_n[2:0];
			end else begin
				res.form        = (cls == movd_pkg::CLS_MACC) ? movd_pkg::FORM_MACC
					: movd_pkg::FORM_AMEM;
				res.word_size   = opcode_n[0];
				res.to_register = (cls == movd_pkg::CLS_MACC);
				res.rm_code     = movd_pkg::RM_DIRECT;
				res.direct_address = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 3'd0;
			opcode_q <= 8'h00;
			modrm_q  <= 8'h00;
			disp_q   <= 16'h0000;
			imm_q    <= 16'h0000;
			explen_q <= 3'd0;
		end else if (step) begin
			pos_q    <= last ? 3'd0 : pos_n;
			opcode_q <= opcode_n;
			modrm_q  <= modrm_n;
			disp_q   <= disp_n;
			imm_q    <= imm_n;
			explen_q <= explen_n;
		end
	end

	assign gout.valid = step && last;
	assign gout.data  = res;

endmodule
